// ----- hw/rtl/crqs_pkg.sv -----
`default_nettype none
package crqs_pkg;
  localparam int QueueDepth = 16;
  localparam int MaxCpus = 16;
  localparam int IdBits = 8;
  localparam int TimeBits = 16;
  localparam int QIdxBits = $clog2(QueueDepth);
  localparam int FillBits = $clog2(QueueDepth + 1);
  localparam int CpuBits = 4;

  typedef enum logic [2:0] {
    FUNC_IDLE = 3'd0, FUNC_PREEMPT = 3'd1, FUNC_YIELD = 3'd2,
    FUNC_TERMINATE = 3'd3, FUNC_WAKE_UP = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    KIND_RUN = 2'd0, KIND_IDLE = 2'd1, KIND_PREEMPT = 2'd2, KIND_DROP = 2'd3
  } kind_t;

  localparam logic [1:0] ModeSrtf = 2'd2;
  localparam logic [1:0] RegMode = 2'd0;
  localparam logic [1:0] RegSlice = 2'd1;
  localparam logic [1:0] RegCpuCount = 2'd2;

  // Control from the sequencer to every queue cell.
  typedef struct packed {
    logic          push;     // write push data into the cell at the fill index
    logic [QIdxBits-1:0] fill_idx;
    logic          remove;   // cells at or above the pick index take their upper neighbour
    logic [QIdxBits-1:0] pick_idx;
  } qctl_t;
endpackage
`default_nettype wire

// ----- hw/rtl/crqs_cell.sv -----
`default_nettype none
// One queue entry. On a removal, each cell at or above the pick takes its upper neighbour.
module crqs_cell
  import crqs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic [QIdxBits-1:0] idx,
  input  wire qctl_t               ctl,
  input  wire logic [IdBits-1:0]   push_id,
  input  wire logic [TimeBits-1:0] push_time,
  input  wire logic [IdBits-1:0]   up_id,
  input  wire logic [TimeBits-1:0] up_time,
  output logic [IdBits-1:0]        id,
  output logic [TimeBits-1:0]      tm
);
  always_ff @(posedge clk) begin
    if (ctl.push && ctl.fill_idx == idx) begin
      id <= push_id;
      tm <= push_time;
    end else if (ctl.remove && idx >= ctl.pick_idx) begin
      id <= up_id;
      tm <= up_time;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/crqs_queue.sv -----
`default_nettype none
// Row of queue cells with a single read port for the sequential walk.
module crqs_queue
  import crqs_pkg::*;
(
  input  wire logic                clk,
  input  wire qctl_t               ctl,
  input  wire logic [IdBits-1:0]   push_id,
  input  wire logic [TimeBits-1:0] push_time,
  input  wire logic [QIdxBits-1:0] rd_idx,
  output logic [IdBits-1:0]        rd_id,
  output logic [TimeBits-1:0]      rd_time
);
  logic [IdBits-1:0]   ids [QueueDepth];
  logic [TimeBits-1:0] tms [QueueDepth];

  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    if (g == QueueDepth - 1) begin : g_top
      crqs_cell u_cell (
        .clk, .idx(QIdxBits'(g)), .ctl, .push_id, .push_time,
        .up_id(ids[g]), .up_time(tms[g]), .id(ids[g]), .tm(tms[g])
      );
    end else begin : g_mid
      crqs_cell u_cell (
        .clk, .idx(QIdxBits'(g)), .ctl, .push_id, .push_time,
        .up_id(ids[g+1]), .up_time(tms[g+1]), .id(ids[g]), .tm(tms[g])
      );
    end
  end

  assign rd_id   = ids[rd_idx];
  assign rd_time = tms[rd_idx];
endmodule
`default_nettype wire

// ----- hw/rtl/cpu_ready_queue_scheduler_top.sv -----
`default_nettype none
// Ready-queue scheduler for up to 16 CPUs.
// Events enter on the s_axis channel (tdata: func, cpu, proc_id, remaining).
// Each event gives at most one result on m_axis (tdata: kind, target_cpu,
// run_id, slice). Registers mode, time slice and CPU count must be written via
// cfg_we / cfg_index / cfg_data while no event is in progress; the block does not check.
// One event is handled at a time. A dispatch walks the queue one entry per
// cycle for the SRTF search and then shifts the cell row; an SRTF wake_up
// walks the CPU table one CPU per cycle. The queue fill or the CPU count
// sets the length of these walks. A wake_up outside SRTF that is not dropped
// gives no result.
// s_axis_tready is low while an event is in progress and while a result
// waits in the output register; a stalled receiver holds the result stable
// and blocks further events until the transaction completes.
// Reset empties the queue, marks all CPUs idle and sets mode FIFO, slice 0
// and a CPU count of 1.
module cpu_ready_queue_scheduler_top
  import crqs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // func[2:0] cpu[6:3] proc_id[14:7] remaining[30:15]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // kind[1:0] target_cpu[5:2] run_id[13:6] slice[29:14]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001, ST_SEARCH = 5'b00010, ST_TAKE = 5'b00100,
    ST_SCAN = 5'b01000, ST_OUT = 5'b10000
  } state_t;

  state_t state;
  logic [1:0]  mode;
  logic [15:0] time_slice;
  logic [4:0]  cpus_in_use;
  logic [FillBits-1:0] fill;
  logic [MaxCpus-1:0]  run_valid;
  logic [IdBits-1:0]   run_ids [MaxCpus];
  logic [TimeBits-1:0] run_times [MaxCpus];

  logic [CpuBits-1:0]  ev_cpu;
  logic [TimeBits-1:0] ev_rem;
  logic [QIdxBits-1:0] walk, pick;
  logic [TimeBits-1:0] best;
  logic [4:0]          scan_n, scan_i;
  logic [CpuBits-1:0]  victim;
  logic [TimeBits-1:0] longest;
  logic [31:0]         out_data;

  qctl_t ctl;
  logic [IdBits-1:0]   push_id;
  logic [TimeBits-1:0] push_time;
  logic [QIdxBits-1:0] rd_idx;
  logic [IdBits-1:0]   rd_id;
  logic [TimeBits-1:0] rd_time;

  logic [2:0]          in_func;
  logic [CpuBits-1:0]  in_cpu;
  logic [IdBits-1:0]   in_pid;
  logic [TimeBits-1:0] in_rem;
  logic                in_fire, full;

  assign in_func = s_axis_tdata[2:0];
  assign in_cpu  = s_axis_tdata[6:3];
  assign in_pid  = s_axis_tdata[14:7];
  assign in_rem  = s_axis_tdata[30:15];
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign full    = fill == FillBits'(QueueDepth);
  assign s_axis_tready = state == ST_IDLE;
  assign m_axis_tvalid = state == ST_OUT;
  assign m_axis_tdata  = out_data;

  always_comb begin
    ctl = '0;
    push_id = in_pid;
    push_time = in_rem;
    ctl.fill_idx = fill[QIdxBits-1:0];
    ctl.pick_idx = pick;
    rd_idx = walk;
    if (state == ST_IDLE && in_fire && !full) begin
      if (in_func == FUNC_WAKE_UP) begin
        ctl.push = 1'b1;
      end else if (in_func == FUNC_PREEMPT && run_valid[in_cpu]) begin
        ctl.push = 1'b1;
        push_id = run_ids[in_cpu];
      end
    end
    if (state == ST_TAKE) begin
      ctl.remove = 1'b1;
      rd_idx = pick;
    end
  end

  crqs_queue u_queue (
    .clk, .ctl, .push_id, .push_time, .rd_idx, .rd_id, .rd_time
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mode <= '0;
      time_slice <= '0;
      cpus_in_use <= 5'd1;
      fill <= '0;
      run_valid <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegMode:     mode <= cfg_data[1:0];
          RegSlice:    time_slice <= cfg_data;
          RegCpuCount: cpus_in_use <= cfg_data[4:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            ev_cpu <= in_cpu;
            ev_rem <= in_rem;
            walk <= '0;
            pick <= '0;
            if (in_func == FUNC_WAKE_UP) begin
              if (full) begin
                out_data <= {2'b0, 16'd0, in_pid, 4'd0, KIND_DROP};
                state <= ST_OUT;
              end else begin
                fill <= fill + 1'b1;
                if (mode == ModeSrtf) begin
                  scan_n <= (cpus_in_use > 5'(MaxCpus)) ? 5'(MaxCpus) : cpus_in_use;
                  scan_i <= '0;
                  longest <= '0;
                  victim <= '0;
                  state <= ST_SCAN;
                end
              end
            end else if (in_func <= FUNC_WAKE_UP) begin
              run_valid[in_cpu] <= 1'b0;
              if (in_func == FUNC_PREEMPT && run_valid[in_cpu] && full) begin
                out_data <= {2'b0, 16'd0, run_ids[in_cpu], in_cpu, KIND_DROP};
                state <= ST_OUT;
              end else begin
                if (in_func == FUNC_PREEMPT && run_valid[in_cpu])
                  fill <= fill + 1'b1;
                state <= ST_SEARCH;
              end
            end
          end
        end
        ST_SEARCH: begin
          if (fill == '0) begin
            out_data <= {2'b0, time_slice, 8'd0, ev_cpu, KIND_IDLE};
            state <= ST_OUT;
          end else if (mode != ModeSrtf) begin
            state <= ST_TAKE;
          end else begin
            if (walk == '0 || best > rd_time) begin
              best <= rd_time;
              pick <= walk;
            end
            if (FillBits'(walk) + 1'b1 >= fill) state <= ST_TAKE;
            else walk <= walk + 1'b1;
          end
        end
        ST_TAKE: begin
          run_ids[ev_cpu] <= rd_id;
          run_times[ev_cpu] <= rd_time;
          run_valid[ev_cpu] <= 1'b1;
          fill <= fill - 1'b1;
          out_data <= {2'b0, time_slice, rd_id, ev_cpu, KIND_RUN};
          state <= ST_OUT;
        end
        ST_SCAN: begin
          if (scan_i >= scan_n) begin
            if (longest > ev_rem) begin
              out_data <= {2'b0, 16'd0, 8'd0, victim, KIND_PREEMPT};
              state <= ST_OUT;
            end else begin
              state <= ST_IDLE;
            end
          end else if (!run_valid[scan_i[CpuBits-1:0]]) begin
            state <= ST_IDLE;
          end else begin
            if (run_times[scan_i[CpuBits-1:0]] > longest) begin
              longest <= run_times[scan_i[CpuBits-1:0]];
              victim <= scan_i[CpuBits-1:0];
            end
            scan_i <= scan_i + 1'b1;
          end
        end
        ST_OUT: if (m_axis_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= FillBits'(QueueDepth))
    else $error("queue fill above depth");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_TAKE |-> fill != '0)
    else $error("dispatch from empty queue");
endmodule
`default_nettype wire
